// File: hw/rtl/dfdo_pkg.sv
// Shared constants, types and a helper function of the coalescing notification queue.
`default_nettype none

package dfdo_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int KEY_W   = 32;
	localparam int PAY_W   = 64;
	localparam int OCC_W   = 7;
	localparam int ENTRY_W = PAY_W + KEY_W + 1;

	localparam int S_TDATA_W = 96;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 104;
	localparam int M_TUSER_W = 4;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic commit;
	} dfdo_cmd_t;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dfdo_ctrl.sv
// Controller state machine: input and output handshakes and datapath sequencing.
`default_nettype none

module dfdo_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output dfdo_pkg::dfdo_cmd_t    cmd
);
	import dfdo_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic m_tvalid_q;
	logic out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// The item takes effect only once the result register can take its result.
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			m_tvalid_q <= cmd.commit || (m_tvalid_q && !m_tready);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire

// File: hw/rtl/dfdo_datapath.sv
// Datapath: key match array, entry memory, ring pointers and result register.
`default_nettype none

module dfdo_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dfdo_pkg::dfdo_cmd_t                cmd,
	input  wire logic [dfdo_pkg::S_TDATA_W-1:0]     in_tdata,
	input  wire logic [dfdo_pkg::S_TUSER_W-1:0]     in_tuser,
	output logic      [dfdo_pkg::M_TDATA_W-1:0]     out_tdata,
	output logic      [dfdo_pkg::M_TUSER_W-1:0]     out_tuser
);
	import dfdo_pkg::*;

	function automatic logic [IDX_W-1:0] first_set(input logic [QUEUE_DEPTH-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

	// Input fields.
	logic             in_cmd;
	logic             in_has;
	logic [KEY_W-1:0] in_key;
	logic [PAY_W-1:0] in_payload;

	assign in_cmd     = in_tuser[0];
	assign in_has     = in_tuser[1];
	assign in_key     = in_tdata[KEY_W-1:0];
	assign in_payload = in_tdata[KEY_W+PAY_W-1:KEY_W];

	// Item held while it is in flight.
	logic             cmd_q;
	logic             has_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] payload_q;

	// Queue state.
	logic [IDX_W-1:0]       head_q;
	logic [IDX_W-1:0]       tail_q;
	logic [CNT_W-1:0]       count_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [KEY_W-1:0]       cam_key_q   [QUEUE_DEPTH];
	logic                   cam_keyed_q [QUEUE_DEPTH];
	logic [ENTRY_W-1:0]     mem_q       [QUEUE_DEPTH];
	logic [ENTRY_W-1:0]     rd_data_q;
	logic [QUEUE_DEPTH-1:0] match_s1;

	// Result register.
	logic             res_pop_valid_q;
	logic [PAY_W-1:0] res_payload_q;
	logic             res_has_q;
	logic [KEY_W-1:0] res_key_q;
	logic             res_replaced_q;
	logic             res_dropped_q;
	logic [OCC_W-1:0] res_occ_q;

	logic [QUEUE_DEPTH-1:0] match_now;
	logic [QUEUE_DEPTH-1:0] from_head;
	logic                   hit;
	logic [IDX_W-1:0]       hit_idx;
	logic                   full;
	logic                   empty;
	logic                   do_push;
	logic                   do_append;
	logic                   do_pop;
	logic [IDX_W-1:0]       wr_idx;
	logic [ENTRY_W-1:0]     wr_entry;
	logic [KEY_W-1:0]       app_key;

	// Every live entry compares against the incoming key at once.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			match_now[i] = valid_q[i] && cam_keyed_q[i] && (cam_key_q[i] == in_key)
				&& in_has && (in_cmd == CMD_PUSH);
			from_head[i] = (IDX_W'(i) >= head_q);
		end
	end

	// The earliest match in queue order lies at or after the head, else from slot zero on.
	assign hit     = |match_s1;
	assign hit_idx = (|(match_s1 & from_head)) ? first_set(match_s1 & from_head)
		: first_set(match_s1);

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = cmd.commit && (cmd_q == CMD_PUSH);
	assign do_append = do_push && !hit;
	assign do_pop    = cmd.commit && (cmd_q == CMD_POP) && !empty;
	assign app_key   = has_q ? key_q : '0;
	assign wr_idx    = hit ? hit_idx : tail_q;
	assign wr_entry  = {payload_q, app_key, has_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			valid_q <= '0;
		end else begin
			if (do_append) begin
				valid_q[tail_q] <= 1'b1;
				tail_q          <= ring_next(tail_q);
				if (full) begin
					// The new item takes the oldest slot, so head and tail move together.
					head_q <= ring_next(head_q);
				end else begin
					count_q <= count_q + 1'b1;
				end
			end else if (do_pop) begin
				valid_q[head_q] <= 1'b0;
				head_q          <= ring_next(head_q);
				count_q         <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= in_cmd;
			has_q     <= in_has;
			key_q     <= in_key;
			payload_q <= in_payload;
			match_s1  <= match_now;
		end
		if (do_append) begin
			cam_key_q[tail_q]   <= app_key;
			cam_keyed_q[tail_q] <= has_q;
		end
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_idx] <= wr_entry;
		end
		if (cmd.load) begin
			rd_data_q <= mem_q[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_pop_valid_q <= do_pop;
			res_payload_q   <= do_pop ? rd_data_q[ENTRY_W-1:KEY_W+1] : '0;
			res_has_q       <= do_pop && rd_data_q[0];
			res_key_q       <= (do_pop && rd_data_q[0]) ? rd_data_q[KEY_W:1] : '0;
			res_replaced_q  <= do_push && hit;
			res_dropped_q   <= do_append && full;
			if (do_append) begin
				res_occ_q <= OCC_W'(full ? count_q : count_q + 1'b1);
			end else if (do_pop) begin
				res_occ_q <= OCC_W'(count_q - 1'b1);
			end else begin
				res_occ_q <= OCC_W'(count_q);
			end
		end
	end

	assign out_tdata = {{(M_TDATA_W - OCC_W - KEY_W - PAY_W){1'b0}},
		res_occ_q, res_key_q, res_payload_q};
	assign out_tuser = {res_dropped_q, res_replaced_q, res_has_q, res_pop_valid_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("valid bits disagree with entry count");

	a_coalesce_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && hit) |=> ($stable(count_q) && $stable(head_q) && $stable(tail_q)))
		else $error("coalesced push moved the ring");

	a_hit_is_live: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && hit) |-> valid_q[hit_idx])
		else $error("coalesced push hit a free slot");

endmodule

`default_nettype wire

// File: hw/rtl/dedup_fifo_drop_oldest_unit.sv
// Top level of the bounded notification queue with key coalescing and drop-oldest overflow.
//
// Input items arrive on the s_ stream: s_tuser carries the command (push or pop) and
// the has-group flag, s_tdata the group key and the payload word. Every input item
// produces exactly one result item on the m_ stream: the popped entry for a pop, the
// replaced and dropped flags for a push, and the occupancy after the item in both cases.
// A push with a key overwrites the payload of the oldest queued entry with that key;
// otherwise it is appended, and when the queue is full the oldest entry is discarded.
// The accept edge registers the key match of all live entries in parallel and the
// entry-memory read at the head; the commit edge, once the result register is free, picks
// the earliest match and updates the ring and the result register. The result is valid
// from the commit edge on, and s_tready returns high at that edge, so a new item is
// accepted only once the last one has taken effect.
// The result register parts the two sides: a new item is accepted while the last result
// waits, but it takes effect only when that result is taken, so a stalled receiver holds
// the queue state and backs up into s_tready.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module dedup_fifo_drop_oldest_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// Fields from bit 0: group_key[31:0], payload[95:32].
	input  wire logic [dfdo_pkg::S_TDATA_W-1:0]     s_tdata,
	// Fields from bit 0: cmd[0], has_group[1].
	input  wire logic [dfdo_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// Fields from bit 0: out_payload[63:0], out_group_key[95:64], occupancy[102:96], zero pad.
	output logic      [dfdo_pkg::M_TDATA_W-1:0]     m_tdata,
	// Fields from bit 0: pop_valid[0], out_has_group[1], was_replaced[2], dropped_oldest[3].
	output logic      [dfdo_pkg::M_TUSER_W-1:0]     m_tuser
);
	import dfdo_pkg::*;

	dfdo_cmd_t cmd;

	dfdo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	dfdo_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_tdata  (s_tdata),
		.in_tuser  (s_tuser),
		.out_tdata (m_tdata),
		.out_tuser (m_tuser)
	);

endmodule

`default_nettype wire
